FILE: sv/nlpf_pkg.sv
`timescale 1ns / 1ps
// Package for the newline packet framer with timeout.
// Holds the widths, codes and state type used by the framer top level.
package nlpf_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);
  localparam int DATA_W      = 8;
  localparam int AGE_W       = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [AGE_W-1:0]  TIMEOUT_RESET    = 16'd100;
  localparam logic [DATA_W-1:0] TERMINATOR_RESET = 8'd10;
  localparam logic [AGE_W-1:0]  AGE_MAX          = {AGE_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR = 8'd1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 2'd0,
    KIND_TOO_LONG = 2'd1,
    KIND_TIMEOUT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SEND
  } state_t;

endpackage

FILE: sv/newline_packet_framer_with_timeout_top.sv
`timescale 1ns / 1ps
// Newline packet framer with timeout: collects bytes into a packet store and
// replays them as a framed stream. Depends on nlpf_pkg.
//
// Throughput: while collecting, one input word per cycle when the output
// register is free. A drop marker appears in the cycle after the word that
// causes it. A finished packet is read back from the store one byte at a
// time (read, then register), and input is held off until its last byte is sent.
// Reset: synchronous; returns to idle with timeout 100 and terminator 10.
// The store needs no clearing pass since only written entries are read.
module newline_packet_framer_with_timeout_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nlpf_pkg::DATA_W-1:0]       s_tdata,   // data
  input  logic                              s_tuser,   // action
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nlpf_pkg::DATA_W-1:0]       m_tdata,   // data_res
  output logic [nlpf_pkg::KIND_W-1:0]       m_tuser,   // kind
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nlpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nlpf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nlpf_pkg::*;

  state_t              state, state_next;
  logic                collecting, collecting_next;
  logic [FILL_W-1:0]   fill_count, fill_count_next;
  logic [AGE_W-1:0]    idle_age, idle_age_next;
  logic [ADDR_W-1:0]   rd_idx, rd_idx_next;
  logic [AGE_W-1:0]    timeout_ticks;
  logic [DATA_W-1:0]   terminator_byte;

  logic [DATA_W-1:0]   store [MAX_PAYLOAD];
  logic [DATA_W-1:0]   rd_data;

  logic                out_free;
  logic                in_fire;
  logic [AGE_W-1:0]    age_inc;
  logic                is_tick;
  logic                hit_timeout;
  logic                hit_full;
  logic                hit_term;
  logic                send_last;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic                out_load;
  kind_t               out_kind;
  logic [DATA_W-1:0]   out_data;
  logic                out_last;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign is_tick   = (s_tuser == ACT_TICK);
  assign age_inc   = (idle_age == AGE_MAX) ? idle_age : idle_age + 1'b1;
  assign hit_timeout = collecting && (age_inc > timeout_ticks);
  assign hit_full  = (fill_count == FILL_W'(MAX_PAYLOAD));
  assign hit_term  = (s_tdata == terminator_byte);
  assign send_last = ({1'b0, rd_idx} + 1'b1) == fill_count;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_fire && !is_tick && collecting && !hit_full && hit_term) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          state_next = send_last ? ST_RUN : ST_READ;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Outputs and control strobes.
  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = fill_count[ADDR_W-1:0];
    rd_en    = 1'b0;
    out_load = 1'b0;
    out_kind = KIND_BYTE;
    out_data = rd_data;
    out_last = send_last;
    case (state)
      ST_RUN: begin
        s_tready = out_free;
        if (in_fire) begin
          if (is_tick) begin
            if (hit_timeout) begin
              out_load = 1'b1;
              out_kind = KIND_TIMEOUT;
              out_data = '0;
              out_last = 1'b1;
            end
          end else if (!collecting) begin
            wr_en   = 1'b1;
            wr_addr = '0;
          end else if (hit_full) begin
            out_load = 1'b1;
            out_kind = KIND_TOO_LONG;
            out_data = '0;
            out_last = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_SEND: begin
        out_load = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Framing state.
  always_comb begin
    collecting_next = collecting;
    fill_count_next = fill_count;
    idle_age_next   = idle_age;
    rd_idx_next     = rd_idx;
    case (state)
      ST_RUN: begin
        if (in_fire) begin
          if (is_tick) begin
            idle_age_next = age_inc;
            if (hit_timeout) begin
              collecting_next = 1'b0;
              fill_count_next = '0;
              idle_age_next   = '0;
            end
          end else begin
            idle_age_next = '0;
            if (!collecting) begin
              collecting_next = 1'b1;
              fill_count_next = FILL_W'(1);
            end else if (hit_full) begin
              collecting_next = 1'b0;
              fill_count_next = '0;
            end else begin
              fill_count_next = fill_count + 1'b1;
              rd_idx_next     = '0;
            end
          end
        end
      end
      ST_SEND: begin
        if (out_free) begin
          if (send_last) begin
            collecting_next = 1'b0;
            fill_count_next = '0;
            idle_age_next   = '0;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end
      default: begin
        rd_idx_next = rd_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      collecting <= 1'b0;
      fill_count <= '0;
      idle_age   <= '0;
      rd_idx     <= '0;
    end else begin
      state      <= state_next;
      collecting <= collecting_next;
      fill_count <= fill_count_next;
      idle_age   <= idle_age_next;
      rd_idx     <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      terminator_byte <= TERMINATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end else if (cfg_index == REG_TERMINATOR) begin
        terminator_byte <= cfg_data[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data;
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for newline_packet_framer_with_timeout_top.
// A built-in framing predictor checks every output word; depends on nlpf_pkg.
module tb_top;
  import nlpf_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES    = 50;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 5000;
  localparam int WORDS_PER_PHASE = 20;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] data;
    logic              last;
  } framer_word_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [DATA_W-1:0]      m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  framer_word_t      expected_out[$];
  int                errors = 0;
  int                quiet_cycles = 0;
  int                words_sent = 0;
  bit                src_random = 1'b0;
  bit                sink_random = 1'b0;
  bit                hold_request = 1'b0;
  logic [AGE_W-1:0]  timeout_now = TIMEOUT_RESET;
  logic [DATA_W-1:0] term_now = TERMINATOR_RESET;

  logic              pr_collecting;
  logic [FILL_W-1:0] pr_fill;
  logic [DATA_W-1:0] pr_store [MAX_PAYLOAD];
  logic [AGE_W-1:0]  pr_age;
  logic [AGE_W-1:0]  pr_timeout;
  logic [DATA_W-1:0] pr_term;

  newline_packet_framer_with_timeout_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic push_expected(input kind_t k, input logic [DATA_W-1:0] d, input logic l);
    expected_out.push_back(framer_word_t'{kind: k, data: d, last: l});
  endtask

  task automatic close_packet();
    pr_collecting = 1'b0;
    pr_fill = '0;
    pr_age = '0;
  endtask

  task automatic predict_framing(input logic act, input logic [DATA_W-1:0] din);
    if (act == ACT_TICK) begin
      if (pr_age != AGE_MAX) pr_age = pr_age + 1'b1;
      if (pr_collecting && pr_age > pr_timeout) begin
        push_expected(KIND_TIMEOUT, '0, 1'b1);
        close_packet();
      end
    end else begin
      pr_age = '0;
      if (!pr_collecting) begin
        pr_store[0] = din;
        pr_fill = FILL_W'(1);
        pr_collecting = 1'b1;
      end else if (pr_fill >= MAX_PAYLOAD) begin
        push_expected(KIND_TOO_LONG, '0, 1'b1);
        close_packet();
      end else begin
        pr_store[pr_fill] = din;
        pr_fill = pr_fill + 1'b1;
        if (din == pr_term) begin
          for (int i = 0; i < pr_fill; i++) begin
            push_expected(KIND_BYTE, pr_store[i], (i == pr_fill - 1));
          end
          close_packet();
        end
      end
    end
  endtask

  always @(posedge clk) begin : out_check
    framer_word_t want;
    if (rst) begin
      pr_timeout = TIMEOUT_RESET;
      pr_term = TERMINATOR_RESET;
      close_packet();
      expected_out.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TIMEOUT) pr_timeout = cfg_data;
        else if (cfg_index == REG_TERMINATOR) pr_term = cfg_data[DATA_W-1:0];
      end
      if (s_tvalid && s_tready) predict_framing(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          note_error($sformatf("unexpected word: kind %0d data %02h last %0b",
                               m_tuser, m_tdata, m_tlast));
        end else begin
          want = expected_out.pop_front();
          if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.last) begin
            note_error($sformatf(
                "mismatch: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
                want.kind, want.data, want.last, m_tuser, m_tdata, m_tlast));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : sink
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_random) begin
        n = gap_length();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic act, input logic [DATA_W-1:0] din);
    int n;
    n = src_random ? gap_length() : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= din;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIMEOUT) timeout_now = val;
    else if (idx == REG_TERMINATOR) term_now = val[DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [AGE_W-1:0] tmo, input logic [DATA_W-1:0] term);
    wait_drained();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_TERMINATOR, {8'h00, term});
  endtask

  // Opens a packet of nbytes bytes, none after the first equal to the terminator.
  task automatic send_open(input int nbytes, input int tick_max);
    logic [DATA_W-1:0] b;
    send_word(ACT_BYTE, 8'($urandom));
    for (int i = 1; i < nbytes; i++) begin
      if (tick_max > 0 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, tick_max)) send_word(ACT_TICK, 8'($urandom));
      end
      do b = 8'($urandom); while (b == term_now);
      send_word(ACT_BYTE, b);
    end
  endtask

  task automatic send_packet(input int nbytes, input int tick_max);
    send_open(nbytes - 1, tick_max);
    send_word(ACT_BYTE, term_now);
  endtask

  task automatic test_basic_framing();
    send_word(ACT_BYTE, TERMINATOR_RESET);
    send_word(ACT_BYTE, TERMINATOR_RESET);
    send_word(ACT_TICK, 8'hFF);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h55);
    send_word(ACT_BYTE, TERMINATOR_RESET);
  endtask

  task automatic test_timeouts();
    set_config(16'd1, TERMINATOR_RESET);
    send_word(ACT_BYTE, 8'h11);
    send_word(ACT_TICK, 8'h00);
    send_word(ACT_BYTE, 8'h22);
    send_word(ACT_TICK, 8'h00);
    send_word(ACT_TICK, 8'h00);
    set_config(16'd0, TERMINATOR_RESET);
    send_word(ACT_TICK, 8'hAA);
    send_word(ACT_BYTE, 8'h33);
    send_word(ACT_TICK, 8'h00);
  endtask

  task automatic test_register_map();
    wait_drained();
    write_reg(8'd2, 16'hFFFF);
    write_reg(8'hFF, 16'h0000);
    write_reg(REG_TIMEOUT, 16'hFFFE);
    write_reg(REG_TERMINATOR, 16'hAB3C);
    send_word(ACT_BYTE, 8'h3C);
    send_word(ACT_BYTE, 8'hC3);
    send_word(ACT_BYTE, 8'h3C);
    set_config(TIMEOUT_RESET, 8'hFF);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
  endtask

  task automatic test_length_limits();
    set_config(TIMEOUT_RESET, TERMINATOR_RESET);
    send_packet(MAX_PAYLOAD, 0);
    send_open(MAX_PAYLOAD, 0);
    send_word(ACT_BYTE, term_now);
    send_open(MAX_PAYLOAD, 0);
    send_word(ACT_BYTE, 8'($urandom));
    send_packet(2, 0);
  endtask

  task automatic test_max_timeout();
    set_config(AGE_MAX, TERMINATOR_RESET);
    send_word(ACT_BYTE, 8'h41);
    repeat (8) send_word(ACT_TICK, 8'h00);
    send_word(ACT_BYTE, term_now);
  endtask

  task automatic test_backpressure();
    wait_drained();
    src_random = 1'b0;
    hold_request = 1'b1;
    repeat (3) send_packet(12, 0);
    src_random = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [AGE_W-1:0]  tmo;
    logic [DATA_W-1:0] term;
    int r;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin tmo = 16'd1;         term = 8'h0A;          end
        1: begin tmo = 16'd3;         term = 8'h00;          end
        2: begin tmo = TIMEOUT_RESET; term = 8'hFF;          end
        3: begin tmo = 16'd2;         term = 8'($urandom);   end
        4: begin tmo = AGE_MAX;       term = 8'($urandom);   end
        default: begin
          tmo = 16'($urandom_range(1, 20));
          term = 8'($urandom);
        end
      endcase
      set_config(tmo, term);
      src_random = (phase != 0);
      sink_random = (phase != 0);
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 10) : $urandom_range(11, MAX_PAYLOAD);
          send_packet(len, (timeout_now < 2) ? int'(timeout_now) : 2);
        end else if (r < 72) begin
          send_open(MAX_PAYLOAD, 0);
          send_word(ACT_BYTE, 8'($urandom));
        end else if (r < 82 && timeout_now <= 200) begin
          send_open($urandom_range(1, 4), 0);
          repeat (int'(timeout_now) + 1) send_word(ACT_TICK, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) send_word(1'($urandom), 8'($urandom));
        end
      end
    end
    src_random = 1'b1;
    sink_random = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= ACT_BYTE;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_random = 1'b1;
    sink_random = 1'b1;

    test_basic_framing();
    test_timeouts();
    test_register_map();
    test_length_limits();
    test_max_timeout();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_out.size() != 0) begin
      note_error($sformatf("%0d expected words never arrived", expected_out.size()));
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
